// ===== rtl/core/lfepi_pkg.sv =====
// ----------------------------------------------------------------------------
// lfepi_pkg
// Shared types and constants of the LFE polyphase interpolator: transaction
// payloads, the tap tag that travels down the MAC pipeline, fixed formats.
// ----------------------------------------------------------------------------
`default_nettype none

package lfepi_pkg;

  // Fixed formats
  localparam int COEF_W      = 24;
  localparam int COEF_DEPTH  = 256;
  localparam int ADDR_W      = $clog2(COEF_DEPTH);
  localparam int BASE_FACTOR = 64;
  localparam int HALF_BASE   = BASE_FACTOR / 2;
  localparam int PHASE_W     = $clog2(BASE_FACTOR);
  localparam int SAMPLE_IN_W = 24;
  localparam int OUT_W       = 28;
  localparam int FRAC_BITS   = 23;
  localparam int RND_BIAS    = 1 << (FRAC_BITS - 1);

  // Parameter defaults
  localparam int DEF_MAX_TAPS     = 8;
  localparam int DEF_SAMPLE_WIDTH = 24;

  // Item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Interpolation modes
  localparam logic MODE_64X  = 1'b0;
  localparam logic MODE_128X = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic signed [SAMPLE_IN_W-1:0] sample;
    logic        [ADDR_W-1:0]      coef_index;
    logic signed [COEF_W-1:0]      coef_value;
  } in_item_t;

  typedef struct packed {
    logic        [PHASE_W-1:0] phase;
    logic signed [OUT_W-1:0]   pcm_first_half;
    logic signed [OUT_W-1:0]   pcm_second_half;
    logic                      last;
  } out_item_t;

  // Tag that follows each coefficient read through the MAC stages
  typedef struct packed {
    logic               vld;
    logic               first;
    logic               last_tap;
    logic [PHASE_W-1:0] phase;
    logic               last;
  } tap_tag_t;

endpackage : lfepi_pkg

`default_nettype wire

// ===== rtl/core/lfepi_ram.sv =====
// ----------------------------------------------------------------------------
// lfepi_ram
// Generic synchronous RAM: one write port, two read ports, registered read
// data held while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module lfepi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads, hold on disable
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule : lfepi_ram

`default_nettype wire

// ===== rtl/core/lfepi_seq.sv =====
// ----------------------------------------------------------------------------
// lfepi_seq
// Front end: input handshake, mode register, sample history and the read
// sequencer that walks the coefficient store once per sample transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lfepi_seq import lfepi_pkg::*; #(
  parameter int MAX_TAPS     = DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int KW = $clog2(MAX_TAPS)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire in_item_t                       in_data,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_data,
  input  wire logic                           adv,
  input  wire logic                           run_done,
  output logic                                ram_wr_en,
  output logic        [ADDR_W-1:0]            ram_wr_addr,
  output logic        [COEF_W-1:0]            ram_wr_data,
  output logic                                ram_rd_en,
  output logic        [ADDR_W-1:0]            ram_rd_addr_a,
  output logic        [ADDR_W-1:0]            ram_rd_addr_b,
  output tap_tag_t                            tag_o,
  output logic signed [SAMPLE_WIDTH-1:0]      samp_o
);

  logic                           busy_r, busy_nxt;
  logic                           run_r, run_nxt;
  logic                           mode_r;
  logic [ADDR_W-1:0]              addr_r, addr_nxt;
  logic [KW-1:0]                  k_r, k_nxt;
  logic [PHASE_W-1:0]             j_r, j_nxt;
  logic [KW-1:0]                  taps_m1;
  logic [PHASE_W-1:0]             half_m1;
  logic                           in_fire, sample_fire, coef_fire;
  logic signed [SAMPLE_WIDTH-1:0] new_samp;
  logic signed [SAMPLE_WIDTH-1:0] hist_r [MAX_TAPS];
  tap_tag_t                       tag_r;
  logic signed [SAMPLE_WIDTH-1:0] samp_r;

  // Input handshake: one transaction at a time, result register decoupled
  assign in_stall    = busy_r;
  assign in_fire     = in_valid && !busy_r;
  assign sample_fire = in_fire && (in_data.cmd == CMD_SAMPLE);
  assign coef_fire   = in_fire && (in_data.cmd == CMD_COEF);

  // Coefficient writes go straight to the store
  assign ram_wr_en   = coef_fire;
  assign ram_wr_addr = in_data.coef_index;
  assign ram_wr_data = in_data.coef_value;

  // Mode register, always ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_64X;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  assign taps_m1 = (mode_r == MODE_128X) ? KW'(MAX_TAPS / 2 - 1) : KW'(MAX_TAPS - 1);
  assign half_m1 = (mode_r == MODE_128X) ? PHASE_W'(2 * HALF_BASE - 1)
                                         : PHASE_W'(HALF_BASE - 1);

  // Take the sample to the history width, sign-extended or truncated
  assign new_samp = SAMPLE_WIDTH'(in_data.sample);

  // Shift the history on each sample transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (sample_fire) begin
      for (int i = MAX_TAPS - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= new_samp;
    end
  end

  // Read sequencer: address runs j*taps+k, mirrored address is its complement
  always_comb begin
    run_nxt  = run_r;
    addr_nxt = addr_r;
    k_nxt    = k_r;
    j_nxt    = j_r;
    priority if (sample_fire) begin
      run_nxt  = 1'b1;
      addr_nxt = '0;
      k_nxt    = '0;
      j_nxt    = '0;
    end else if (run_r && adv) begin
      addr_nxt = addr_r + 1'b1;
      if (k_r == taps_m1) begin
        k_nxt = '0;
        if (j_r == half_m1) begin
          run_nxt = 1'b0;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  // Busy from accept until the final result sits in the output register
  always_comb begin
    busy_nxt = busy_r;
    priority if (sample_fire) begin
      busy_nxt = 1'b1;
    end else if (run_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      run_r  <= 1'b0;
      addr_r <= '0;
      k_r    <= '0;
      j_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      run_r  <= run_nxt;
      addr_r <= addr_nxt;
      k_r    <= k_nxt;
      j_r    <= j_nxt;
    end
  end

  assign ram_rd_en     = adv;
  assign ram_rd_addr_a = addr_r;
  assign ram_rd_addr_b = ~addr_r;

  // Tag and sample operand, aligned with the RAM read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else if (adv) begin
      tag_r.vld <= run_r;
    end
    if (adv) begin
      tag_r.first    <= (k_r == '0);
      tag_r.last_tap <= (k_r == taps_m1);
      tag_r.phase    <= j_r;
      tag_r.last     <= (j_r == half_m1);
      samp_r         <= hist_r[k_r];
    end
  end

  assign tag_o  = tag_r;
  assign samp_o = samp_r;

endmodule : lfepi_seq

`default_nettype wire

// ===== rtl/core/lfepi_mac.sv =====
// ----------------------------------------------------------------------------
// lfepi_mac
// Back end: two multiply-accumulate lanes (direct and mirrored coefficient),
// rounding with saturation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfepi_mac import lfepi_pkg::*; #(
  parameter int MAX_TAPS     = DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int KW = $clog2(MAX_TAPS)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  output logic                                adv,
  output logic                                run_done,
  input  wire tap_tag_t                       tag_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] samp_i,
  input  wire logic        [COEF_W-1:0]       coef_a_i,
  input  wire logic        [COEF_W-1:0]       coef_b_i,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output out_item_t                           out_data
);

  localparam int PW = COEF_W + SAMPLE_WIDTH;
  localparam int AW = PW + KW;
  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (OUT_W - 1));

  tap_tag_t              tag_p_r, tag_c_r;
  logic signed [PW-1:0]  prod_a_r, prod_b_r;
  logic signed [AW-1:0]  acc_a_r, acc_b_r;
  logic signed [COEF_W-1:0] coef_a, coef_b;
  logic signed [AW:0]    rnd_a, rnd_b;
  logic signed [63:0]    q_a, q_b;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r;
  logic                  res_ready;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  // Freeze the whole pipeline while a result waits on a stalled sink
  assign adv = !(out_valid_r && out_stall);

  assign coef_a = coef_a_i;
  assign coef_b = coef_b_i;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_p_r.vld <= 1'b0;
    end else if (adv) begin
      tag_p_r.vld <= tag_i.vld;
    end
    if (adv) begin
      tag_p_r.first    <= tag_i.first;
      tag_p_r.last_tap <= tag_i.last_tap;
      tag_p_r.phase    <= tag_i.phase;
      tag_p_r.last     <= tag_i.last;
      prod_a_r         <= coef_a * samp_i;
      prod_b_r         <= coef_b * samp_i;
    end
  end

  // Accumulate stage: restart on the first tap of each phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_c_r.vld <= 1'b0;
    end else if (adv) begin
      tag_c_r.vld <= tag_p_r.vld;
    end
    if (adv) begin
      tag_c_r.first    <= tag_p_r.first;
      tag_c_r.last_tap <= tag_p_r.last_tap;
      tag_c_r.phase    <= tag_p_r.phase;
      tag_c_r.last     <= tag_p_r.last;
      if (tag_p_r.first) begin
        acc_a_r <= AW'(prod_a_r);
        acc_b_r <= AW'(prod_b_r);
      end else begin
        acc_a_r <= acc_a_r + AW'(prod_a_r);
        acc_b_r <= acc_b_r + AW'(prod_b_r);
      end
    end
  end

  // Round half up at the fractional shift, then saturate
  assign rnd_a = (AW + 1)'(acc_a_r) + (AW + 1)'(RND_BIAS);
  assign rnd_b = (AW + 1)'(acc_b_r) + (AW + 1)'(RND_BIAS);
  assign q_a   = 64'(rnd_a >>> FRAC_BITS);
  assign q_b   = 64'(rnd_b >>> FRAC_BITS);

  assign res_ready = adv && tag_c_r.vld && tag_c_r.last_tap;
  assign run_done  = res_ready && tag_c_r.last;

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      out_data_r.phase           <= tag_c_r.phase;
      out_data_r.pcm_first_half  <= sat_out(q_a);
      out_data_r.pcm_second_half <= sat_out(q_b);
      out_data_r.last            <= tag_c_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : lfepi_mac

`default_nettype wire

// ===== rtl/core/lfe_polyphase_interpolator_unit.sv =====
// Sample transaction: a result is registered as the last tap of each phase leaves the
//   accumulate stage; a stalled sink holds the pipeline. A run reads all 256 addresses.
// The input stalls from a sample's accept until its final result is in the output
//   register; a coefficient write opens no run. The single read port pair sets its length.
// Reset (synchronous, active low) clears the history, mode and control state;
//   the coefficient store holds no defined value until written.
// ----------------------------------------------------------------------------
// lfe_polyphase_interpolator_unit
// Polyphase FIR interpolator for the LFE channel, 64x or 128x, built around a
// dual-read coefficient store and a pipelined pair of MAC lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module lfe_polyphase_interpolator_unit import lfepi_pkg::*; #(
  parameter int MAX_TAPS     = DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  logic                           adv, run_done;
  logic                           ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]              ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
  logic [COEF_W-1:0]              ram_wr_data, ram_rd_data_a, ram_rd_data_b;
  tap_tag_t                       tag;
  logic signed [SAMPLE_WIDTH-1:0] samp;

  // Mode register takes every write
  assign cfg_ready = 1'b1;

  lfepi_seq #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .adv           (adv),
    .run_done      (run_done),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr_a (ram_rd_addr_a),
    .ram_rd_addr_b (ram_rd_addr_b),
    .tag_o         (tag),
    .samp_o        (samp)
  );

  lfepi_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_en     (ram_rd_en),
    .rd_addr_a (ram_rd_addr_a),
    .rd_addr_b (ram_rd_addr_b),
    .rd_data_a (ram_rd_data_a),
    .rd_data_b (ram_rd_data_b)
  );

  lfepi_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .run_done  (run_done),
    .tag_i     (tag),
    .samp_i    (samp),
    .coef_a_i  (ram_rd_data_a),
    .coef_b_i  (ram_rd_data_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule : lfe_polyphase_interpolator_unit

`default_nettype wire

// ===== rtl/core/lfepi_checker.sv =====
// ----------------------------------------------------------------------------
// lfepi_checker
// Port-level checks of the interpolator: run framing against the input
// handshake, result hold under stall, reset of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lfepi_checker import lfepi_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A sample transaction opens a run that blocks the input
  a_run_opens: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == CMD_SAMPLE) |=> in_stall)
    else $error("input not stalled after sample transaction");

  // A coefficient write produces no run
  a_coef_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == CMD_COEF) |=> !in_stall)
    else $error("input stalled after coefficient write");

  // Results before the final one of a run are shown only while busy
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input open while a run is unfinished");

  // Drop the result channel on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule : lfepi_checker

bind lfe_polyphase_interpolator_unit lfepi_checker u_lfepi_checker (.*);

`default_nettype wire
